>>> sv/assert_macros.svh
// Assertion macros shared by the page cache state table RTL.
// No dependencies; included by modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check sampled on the rising clock edge, muted while reset is asserted (active low).
`define ASSERT_RST(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Check sampled on the rising clock edge, live through reset as well.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> sv/pcst_pkg.sv
// Types and constants for the page cache state table.
// No dependencies; used by pcst_update and page_cache_state_table_core.
`default_nettype none

package pcst_pkg;

    // Field widths fixed by the interface
    localparam int PCST_KIND_W  = 3;
    localparam int PCST_IDX_W   = 10;
    localparam int PCST_VER_W   = 5;
    localparam int PCST_PIU_W   = 11;

    // Default table depth
    localparam int PCST_PAGE_COUNT_MAX = 1024;

    // Configuration space
    localparam int                    PCST_PADDR_W          = 3;
    localparam logic                  PCST_REG_PAGES_IN_USE = 1'b0;
    localparam logic [PCST_PIU_W-1:0] PCST_PIU_RESET        = 11'd1024;

    // Event kinds
    typedef enum logic [PCST_KIND_W-1:0] {
        KIND_READ         = 3'd0,
        KIND_WRITE        = 3'd1,
        KIND_OTHER        = 3'd2,
        KIND_MARK         = 3'd3,
        KIND_RECLAIM      = 3'd4,
        KIND_PROMOTE_DONE = 3'd5
    } pcst_kind_t;

    // Per-page cache state
    typedef enum logic [1:0] {
        PG_UNCACHED  = 2'd0,
        PG_PENDING   = 2'd1,
        PG_PROMOTING = 2'd2,
        PG_CACHED    = 2'd3
    } pcst_page_state_t;

    // One table entry
    typedef struct packed {
        logic [PCST_VER_W-1:0] version;
        pcst_page_state_t      state;
    } pcst_entry_t;

    localparam int PCST_ENTRY_W = $bits(pcst_entry_t);

    // One result beat
    typedef struct packed {
        pcst_page_state_t      state_after;
        logic                  in_range;
        logic                  promote_write;
        logic [PCST_VER_W-1:0] promote_tag;
        logic                  start_promote;
        logic                  to_upper;
        logic                  to_lower;
    } pcst_result_t;

endpackage

`default_nettype wire

>>> sv/pcst_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the page state table.
`default_nettype none

module pcst_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              aclk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Read port; same-address write in the same cycle returns old data
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

`default_nettype wire

>>> sv/pcst_update.sv
// Event logic for one page: next entry and routing result.
// Depends on pcst_pkg.
`default_nettype none

module pcst_update
    import pcst_pkg::*;
(
    input  wire pcst_kind_t            kind,
    input  wire logic [PCST_VER_W-1:0] version_tag,
    input  wire logic                  in_range,
    input  wire pcst_entry_t           cur_entry,
    output pcst_entry_t                new_entry,
    output logic                       wr_en,
    output pcst_result_t               result
);

    always_comb begin
        new_entry = cur_entry;
        wr_en     = 1'b0;
        result    = '0;
        if (in_range) begin
            wr_en           = 1'b1;
            result.in_range = 1'b1;
            case (kind)
                KIND_READ: begin
                    if (cur_entry.state == PG_CACHED) begin
                        result.to_upper = 1'b1;
                    end else begin
                        result.to_lower = 1'b1;
                        if (cur_entry.state == PG_PENDING) begin
                            result.start_promote = 1'b1;
                            result.promote_tag   = cur_entry.version;
                            new_entry.state      = PG_PROMOTING;
                        end
                    end
                end
                KIND_WRITE: begin
                    result.to_lower = 1'b1;
                    if (cur_entry.state != PG_UNCACHED) begin
                        result.to_upper = 1'b1;
                        new_entry.state = PG_CACHED;
                    end
                end
                KIND_OTHER: begin
                    result.to_lower = 1'b1;
                end
                KIND_MARK: begin
                    if (cur_entry.state == PG_UNCACHED) begin
                        new_entry.state = PG_PENDING;
                    end
                end
                KIND_RECLAIM: begin
                    // version wraps at its field width
                    if (cur_entry.state != PG_UNCACHED) begin
                        new_entry.state   = PG_UNCACHED;
                        new_entry.version = cur_entry.version + 1'b1;
                    end
                end
                KIND_PROMOTE_DONE: begin
                    if (cur_entry.state == PG_PROMOTING && cur_entry.version == version_tag) begin
                        result.promote_write = 1'b1;
                        new_entry.state      = PG_CACHED;
                    end else begin
                        new_entry.state = PG_PENDING;
                    end
                end
                default: begin
                    // unused kinds leave the entry as is
                end
            endcase
            result.state_after = new_entry.state;
        end
    end

endmodule

`default_nettype wire

>>> sv/page_cache_state_table_core.sv
// Page cache state table: per-page state and version with event routing.
// Each accepted input beat is registered into the entry stage with its table read, then into the result register.
// Throughput: one beat per cycle unless the result channel stalls; one table read-modify-write
// per beat with forwarding from the previous write. Reset is synchronous, active low; after it
// a clearing sweep writes PAGE_COUNT_MAX entries, one per cycle, with s_tready low.
`default_nettype none
`include "assert_macros.svh"

module page_cache_state_table_core
    import pcst_pkg::*;
#(
    parameter int PAGE_COUNT_MAX = PCST_PAGE_COUNT_MAX
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    // input stream
    input  wire logic                    s_tvalid,
    output logic                         s_tready,
    input  wire logic [15:0]             s_tdata,  // page_index[9:0], version_tag[14:10], 0
    input  wire logic [2:0]              s_tuser,  // kind[2:0]
    // result stream
    output logic                         m_tvalid,
    input  wire logic                    m_tready,
    // to_lower[0], to_upper[1], start_promote[2], promote_tag[7:3],
    // promote_write[8], in_range[9], state_after[11:10], 0
    output logic      [15:0]             m_tdata,
    // configuration
    input  wire logic                    psel,
    input  wire logic                    penable,
    input  wire logic                    pwrite,
    input  wire logic [PCST_PADDR_W-1:0] paddr,
    input  wire logic [31:0]             pwdata,
    output logic      [31:0]             prdata,
    output logic                         pready
);

    localparam int AW      = $clog2(PAGE_COUNT_MAX);
    localparam int CNT_W   = $clog2(PAGE_COUNT_MAX + 1);
    localparam int CW      = (CNT_W > PCST_PIU_W) ? CNT_W : PCST_PIU_W;
    localparam logic [AW-1:0] LAST_ADDR = AW'(PAGE_COUNT_MAX - 1);

    typedef enum logic [1:0] {
        CLR_SWEEP = 2'b01,
        CLR_RUN   = 2'b10
    } clr_state_t;

    clr_state_t                clr_state_reg, clr_state_next;
    logic [AW-1:0]             clr_cnt_reg, clr_cnt_next;
    logic [PCST_PIU_W-1:0]     pages_in_use_reg, pages_in_use_next;

    logic                      s1_valid_reg, s1_valid_next;
    pcst_kind_t                s1_kind_reg, s1_kind_next;
    logic [CW-1:0]             s1_idx_reg, s1_idx_next;
    logic [PCST_VER_W-1:0]     s1_tag_reg, s1_tag_next;

    logic                      out_valid_reg, out_valid_next;
    pcst_result_t              result_reg, result_next;

    logic                      fwd_valid_reg, fwd_valid_next;
    logic [AW-1:0]             fwd_addr_reg, fwd_addr_next;
    pcst_entry_t               fwd_data_reg, fwd_data_next;

    logic                      s_fire, s1_advance, s1_fire, cfg_write;
    logic [CW-1:0]             in_idx;
    logic [AW-1:0]             s1_addr;
    logic                      s1_in_range;
    logic [PCST_ENTRY_W-1:0]   ram_rdata, ram_wdata;
    logic                      ram_we;
    logic [AW-1:0]             ram_waddr;
    pcst_entry_t               cur_entry, upd_entry;
    logic                      upd_wr_en;
    pcst_result_t              upd_result;

    // Handshakes
    assign s1_advance = !out_valid_reg || m_tready;
    assign s1_fire    = s1_valid_reg && s1_advance;
    assign s_tready   = (clr_state_reg == CLR_RUN) && (!s1_valid_reg || s1_advance);
    assign s_fire     = s_tvalid && s_tready;
    assign m_tvalid   = out_valid_reg;
    assign in_idx     = CW'(s_tdata[PCST_IDX_W-1:0]);

    // Configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == PCST_REG_PAGES_IN_USE);
    assign prdata    = (paddr[2] == PCST_REG_PAGES_IN_USE) ? 32'(pages_in_use_reg) : '0;
    assign pages_in_use_next = cfg_write ? pwdata[PCST_PIU_W-1:0] : pages_in_use_reg;

    // Clearing sweep after reset
    always_comb begin
        clr_state_next = clr_state_reg;
        clr_cnt_next   = clr_cnt_reg;
        case (clr_state_reg)
            CLR_SWEEP: begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == LAST_ADDR) begin
                    clr_state_next = CLR_RUN;
                end
            end
            CLR_RUN: begin
                clr_cnt_next = clr_cnt_reg;
            end
            default: begin
                clr_state_next = CLR_SWEEP;
            end
        endcase
    end

    // Table store
    pcst_ram #(
        .WIDTH (PCST_ENTRY_W),
        .DEPTH (PAGE_COUNT_MAX),
        .ADDR_W(AW)
    ) u_ram (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (s_fire),
        .raddr(in_idx[AW-1:0]),
        .rdata(ram_rdata)
    );

    // Entry stage: range check and forwarding of the last write
    assign s1_addr     = s1_idx_reg[AW-1:0];
    assign s1_in_range = (s1_idx_reg < CW'(pages_in_use_reg)) &&
                         (s1_idx_reg < CW'(PAGE_COUNT_MAX));
    assign cur_entry   = (fwd_valid_reg && fwd_addr_reg == s1_addr) ? fwd_data_reg
                                                                    : pcst_entry_t'(ram_rdata);

    pcst_update u_update (
        .kind       (s1_kind_reg),
        .version_tag(s1_tag_reg),
        .in_range   (s1_in_range),
        .cur_entry  (cur_entry),
        .new_entry  (upd_entry),
        .wr_en      (upd_wr_en),
        .result     (upd_result)
    );

    // Write mux: sweep or item update
    always_comb begin
        if (clr_state_reg == CLR_SWEEP) begin
            ram_we    = 1'b1;
            ram_waddr = clr_cnt_reg;
            ram_wdata = '0;
        end else begin
            ram_we    = s1_fire && upd_wr_en;
            ram_waddr = s1_addr;
            ram_wdata = upd_entry;
        end
    end

    // Pipeline next values
    always_comb begin
        s1_valid_next  = s1_valid_reg;
        s1_kind_next   = s1_kind_reg;
        s1_idx_next    = s1_idx_reg;
        s1_tag_next    = s1_tag_reg;
        out_valid_next = out_valid_reg;
        result_next    = result_reg;
        fwd_valid_next = fwd_valid_reg;
        fwd_addr_next  = fwd_addr_reg;
        fwd_data_next  = fwd_data_reg;

        if (s1_advance) begin
            s1_valid_next = 1'b0;
        end
        if (s_fire) begin
            s1_valid_next = 1'b1;
            s1_kind_next  = pcst_kind_t'(s_tuser);
            s1_idx_next   = in_idx;
            s1_tag_next   = s_tdata[PCST_IDX_W +: PCST_VER_W];
        end

        if (m_tready) begin
            out_valid_next = 1'b0;
        end
        if (s1_fire) begin
            out_valid_next = 1'b1;
            result_next    = upd_result;
            if (upd_wr_en) begin
                fwd_valid_next = 1'b1;
                fwd_addr_next  = s1_addr;
                fwd_data_next  = upd_entry;
            end
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_state_reg    <= CLR_SWEEP;
            clr_cnt_reg      <= '0;
            pages_in_use_reg <= PCST_PIU_RESET;
            s1_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            fwd_valid_reg    <= 1'b0;
        end else begin
            clr_state_reg    <= clr_state_next;
            clr_cnt_reg      <= clr_cnt_next;
            pages_in_use_reg <= pages_in_use_next;
            s1_valid_reg     <= s1_valid_next;
            out_valid_reg    <= out_valid_next;
            fwd_valid_reg    <= fwd_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        s1_kind_reg  <= s1_kind_next;
        s1_idx_reg   <= s1_idx_next;
        s1_tag_reg   <= s1_tag_next;
        result_reg   <= result_next;
        fwd_addr_reg <= fwd_addr_next;
        fwd_data_reg <= fwd_data_next;
    end

    // Result beat packing
    assign m_tdata = {4'b0000, result_reg.state_after, result_reg.in_range,
                      result_reg.promote_write, result_reg.promote_tag,
                      result_reg.start_promote, result_reg.to_upper, result_reg.to_lower};

    // Checks
    `ASSERT_ALWAYS(a_reset_quiet, aclk, !aresetn |=> (!m_tvalid && !s_tready), "outputs not quiet after reset")
    `ASSERT_RST(a_write_source, aclk, aresetn, (clr_state_reg == CLR_RUN && ram_we) |-> s1_fire, "table written without an item")
    `ASSERT_RST(a_oor_zero, aclk, aresetn, (m_tvalid && !result_reg.in_range) |-> (m_tdata == '0), "out of range result not zero")
    `ASSERT_RST(a_promote_start, aclk, aresetn, (m_tvalid && result_reg.start_promote) |-> (result_reg.to_lower && !result_reg.to_upper && result_reg.state_after == PG_PROMOTING), "bad promote start")
    `ASSERT_RST(a_promote_write, aclk, aresetn, (m_tvalid && result_reg.promote_write) |-> (result_reg.state_after == PG_CACHED && !result_reg.to_lower), "bad promote write")

endmodule

`default_nettype wire

>>> tb/page_cache_state_table_checker.sv
// Checker for the page cache state table: watches the input, result and APB channels.
// Holds its own page table, predicts one result per accepted beat and compares in order.
// Depends on pcst_pkg for the event kinds, page states and the result layout.

module page_cache_state_table_checker
    import pcst_pkg::*;
#(
    parameter logic [PCST_PADDR_W-1:0] PIU_ADDR = '0
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    input  logic                    s_tready,
    input  logic [15:0]             s_tdata,  // page_index[9:0], version_tag[14:10], 0
    input  logic [2:0]              s_tuser,  // kind[2:0]
    input  logic                    m_tvalid,
    input  logic                    m_tready,
    input  logic [15:0]             m_tdata,  // pcst_result_t in [11:0], 0
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic                    pready,
    input  logic [PCST_PADDR_W-1:0] paddr,
    input  logic [31:0]             pwdata,
    output int                      mismatches,
    output int                      results_owed,
    output int                      results_checked,
    output int                      promote_copies
);

    // Shadow of the page table and the page count register
    pcst_page_state_t      page_state   [PCST_PAGE_COUNT_MAX];
    logic [PCST_VER_W-1:0] page_version [PCST_PAGE_COUNT_MAX];
    logic [PCST_PIU_W-1:0] piu_shadow;

    // Results predicted but not yet seen on the result channel
    pcst_result_t routing_results[$];

    initial begin
        mismatches      = 0;
        results_owed    = 0;
        results_checked = 0;
        promote_copies  = 0;
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] result %0d: %s", $time, results_checked, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want)
            report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
    endtask

    // One read-modify-write of a page entry; returns the routing it causes
    function automatic pcst_result_t route_page_event(input logic [2:0] kind,
                                                      input logic [PCST_IDX_W-1:0] page,
                                                      input logic [PCST_VER_W-1:0] tag);
        pcst_result_t          r;
        pcst_page_state_t      st;
        logic [PCST_VER_W-1:0] ver;
        r = '0;
        // out of range: nothing changes, all fields zero
        if (page >= piu_shadow || page >= PCST_PAGE_COUNT_MAX)
            return r;
        st  = page_state[page];
        ver = page_version[page];
        case (kind)
            KIND_READ: begin
                if (st == PG_CACHED) begin
                    r.to_upper = 1'b1;
                end else begin
                    r.to_lower = 1'b1;
                    if (st == PG_PENDING) begin
                        r.start_promote = 1'b1;
                        r.promote_tag   = ver;
                        st              = PG_PROMOTING;
                    end
                end
            end
            KIND_WRITE: begin
                r.to_lower = 1'b1;
                if (st != PG_UNCACHED) begin
                    r.to_upper = 1'b1;
                    st         = PG_CACHED;
                end
            end
            KIND_OTHER: begin
                r.to_lower = 1'b1;
            end
            KIND_MARK: begin
                if (st == PG_UNCACHED)
                    st = PG_PENDING;
            end
            KIND_RECLAIM: begin
                // version wraps at its width
                if (st != PG_UNCACHED) begin
                    st  = PG_UNCACHED;
                    ver = ver + 1'b1;
                end
            end
            KIND_PROMOTE_DONE: begin
                if (st == PG_PROMOTING && ver == tag) begin
                    r.promote_write = 1'b1;
                    st              = PG_CACHED;
                end else begin
                    st = PG_PENDING;
                end
            end
            default: begin
                // unused kinds report the state and change nothing
            end
        endcase
        page_state[page]   = st;
        page_version[page] = ver;
        r.in_range         = 1'b1;
        r.state_after      = st;
        return r;
    endfunction

    // Predict at input acceptance, compare at result acceptance
    always @(posedge aclk) begin
        pcst_result_t got;
        pcst_result_t want;
        if (!aresetn) begin
            for (int i = 0; i < PCST_PAGE_COUNT_MAX; i++) begin
                page_state[i]   = PG_UNCACHED;
                page_version[i] = '0;
            end
            piu_shadow = PCST_PIU_RESET;
            routing_results.delete();
        end else begin
            if (psel && penable && pwrite && pready && paddr == PIU_ADDR)
                piu_shadow = pwdata[PCST_PIU_W-1:0];
            if (s_tvalid && s_tready)
                routing_results.push_back(route_page_event(s_tuser,
                                                           s_tdata[PCST_IDX_W-1:0],
                                                           s_tdata[14:10]));
            if (m_tvalid && m_tready) begin
                got = pcst_result_t'(m_tdata[PCST_ENTRY_W+4:0]);
                if (routing_results.size() == 0) begin
                    report_mismatch($sformatf("beat 0x%04h with nothing expected", m_tdata));
                end else begin
                    want = routing_results.pop_front();
                    check_field("to_lower",      got.to_lower,      want.to_lower);
                    check_field("to_upper",      got.to_upper,      want.to_upper);
                    check_field("start_promote", got.start_promote, want.start_promote);
                    check_field("promote_tag",   got.promote_tag,   want.promote_tag);
                    check_field("promote_write", got.promote_write, want.promote_write);
                    check_field("in_range",      got.in_range,      want.in_range);
                    check_field("state_after",   got.state_after,   want.state_after);
                    if (want.promote_write)
                        promote_copies++;
                end
                results_checked++;
            end
        end
        results_owed <= routing_results.size();
    end

endmodule

>>> tb/page_cache_state_table_core_tb.sv
// Testbench top for page_cache_state_table_core: clock, reset, stimulus and verdict.
// Drives page events and APB writes; page_cache_state_table_checker does the checking.
// Depends on pcst_pkg, page_cache_state_table_core and page_cache_state_table_checker.

module page_cache_state_table_core_tb;
    import pcst_pkg::*;

    localparam logic [PCST_PADDR_W-1:0] PIU_ADDR = PCST_PADDR_W'(4 * PCST_REG_PAGES_IN_USE);
    localparam logic [PCST_KIND_W-1:0]  KIND_RESERVED_A = 3'd6;
    localparam logic [PCST_KIND_W-1:0]  KIND_RESERVED_B = 3'd7;
    localparam int                      SETTLE_CYCLES   = 8;
    localparam int                      IDLE_PCT        = 12;

    logic                    aclk     = 1'b0;
    logic                    aresetn  = 1'b0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [15:0]             s_tdata  = '0;  // page_index[9:0], version_tag[14:10], 0
    logic [2:0]              s_tuser  = '0;  // kind[2:0]
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [15:0]             m_tdata;        // pcst_result_t in [11:0], 0
    logic                    psel     = 1'b0;
    logic                    penable  = 1'b0;
    logic                    pwrite   = 1'b0;
    logic [PCST_PADDR_W-1:0] paddr    = '0;
    logic [31:0]             pwdata   = '0;
    logic [31:0]             prdata;
    logic                    pready;

    int mismatches;
    int results_owed;
    int results_checked;
    int promote_copies;

    // Stimulus bookkeeping
    bit                    quiet;
    logic [PCST_PIU_W-1:0] cur_piu = PCST_PIU_RESET;
    int unsigned           beats_sent;
    int unsigned           live_beats;
    int unsigned           settings_used;

    // Last promote tag seen per page, taken from the result channel
    logic [PCST_IDX_W-1:0] pages_in_flight[$];
    bit [PCST_VER_W-1:0]   tag_hint[PCST_PAGE_COUNT_MAX];

    page_cache_state_table_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    page_cache_state_table_checker #(
        .PIU_ADDR (PIU_ADDR)
    ) u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .pready          (pready),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .mismatches      (mismatches),
        .results_owed    (results_owed),
        .results_checked (results_checked),
        .promote_copies  (promote_copies)
    );

    // Clock
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Result side back-pressure
    always @(posedge aclk) begin
        m_tready <= quiet || ($urandom_range(99) >= IDLE_PCT);
    end

    // Track promote tags handed out so promotion-done beats can match them
    always @(posedge aclk) begin
        pcst_result_t beat;
        if (!aresetn) begin
            pages_in_flight.delete();
        end else begin
            if (s_tvalid && s_tready)
                pages_in_flight.push_back(s_tdata[PCST_IDX_W-1:0]);
            if (m_tvalid && m_tready && pages_in_flight.size() != 0) begin
                beat = pcst_result_t'(m_tdata[11:0]);
                if (beat.start_promote)
                    tag_hint[pages_in_flight[0]] <= beat.promote_tag;
                void'(pages_in_flight.pop_front());
            end
        end
    end

    // One input beat, with a random gap in front unless in a quiet stretch
    task automatic send_event(input logic [2:0] kind, input logic [PCST_IDX_W-1:0] page,
                              input logic [PCST_VER_W-1:0] tag);
        if (!quiet) begin
            while ($urandom_range(99) < IDLE_PCT) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {1'b0, tag, page};
        do @(posedge aclk); while (!s_tready);
        beats_sent++;
        // count beats that land on a live page with a defined kind
        if (page < cur_piu && kind <= KIND_PROMOTE_DONE)
            live_beats++;
    endtask

    // Stop sending and wait until every result is back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (results_owed != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // APB write: setup cycle, then access cycle
    task automatic write_pages_in_use(input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PIU_ADDR;
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cur_piu = value[PCST_PIU_W-1:0];
        settings_used++;
    endtask

    function automatic logic [2:0] pick_kind();
        if ($urandom_range(9) == 0)
            return $urandom_range(1) ? KIND_RESERVED_B : KIND_RESERVED_A;
        return 3'($urandom_range(KIND_PROMOTE_DONE));
    endfunction

    // Mostly a few hot pages at either end of the range, some uniform, some out of range
    function automatic logic [PCST_IDX_W-1:0] pick_page(input int unsigned limit,
                                                       input int unsigned hot);
        int unsigned r;
        r = $urandom_range(99);
        if (limit == 0)
            return PCST_IDX_W'($urandom_range(PCST_PAGE_COUNT_MAX - 1));
        if (r < 8 && limit < PCST_PAGE_COUNT_MAX)
            return PCST_IDX_W'($urandom_range(PCST_PAGE_COUNT_MAX - 1, limit));
        if (r < 25)
            return PCST_IDX_W'(limit - 1 - $urandom_range(hot - 1));
        if (r < 40)
            return PCST_IDX_W'($urandom_range(limit - 1));
        return PCST_IDX_W'($urandom_range(hot - 1));
    endfunction

    // One register setting followed by random traffic
    task automatic run_phase(input logic [31:0] piu, input int unsigned target,
                             input bit no_gaps);
        int unsigned           limit;
        int unsigned           hot;
        int unsigned           sent0;
        logic [PCST_IDX_W-1:0] page;
        drain_results();
        write_pages_in_use(piu);
        limit = piu > PCST_PAGE_COUNT_MAX ? PCST_PAGE_COUNT_MAX : piu;
        hot   = limit == 0 ? 1 : (limit < 8 ? limit : 8);
        sent0 = beats_sent;
        quiet = no_gaps;
        while (beats_sent - sent0 < target) begin
            if ($urandom_range(9) < 4) begin
                // promotion flow: mark, read, some other traffic, done, follow-up, maybe a reclaim
                page = pick_page(limit, hot);
                send_event(KIND_MARK, page, PCST_VER_W'($urandom));
                send_event(KIND_READ, page, PCST_VER_W'($urandom));
                repeat ($urandom_range(4))
                    send_event(pick_kind(), pick_page(limit, hot), PCST_VER_W'($urandom));
                send_event(KIND_PROMOTE_DONE, page,
                           $urandom_range(4) != 0 ? tag_hint[page] : PCST_VER_W'($urandom));
                repeat ($urandom_range(2))
                    send_event($urandom_range(1) ? KIND_READ : KIND_WRITE, page,
                               PCST_VER_W'($urandom));
                if ($urandom_range(2) == 0)
                    send_event(KIND_RECLAIM, page, PCST_VER_W'($urandom));
            end else begin
                send_event(pick_kind(), pick_page(limit, hot), PCST_VER_W'($urandom));
            end
        end
        quiet = 1'b0;
    endtask

    // Stimulus and verdict
    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        // clearing sweep holds s_tready low
        do @(posedge aclk); while (!s_tready);

        // Directed: state transitions on page 0, then the top page, at the reset page count
        send_event(KIND_READ,         10'd0,   5'd0);
        send_event(KIND_MARK,         10'd0,   5'd0);
        send_event(KIND_MARK,         10'd0,   5'd0);
        send_event(KIND_READ,         10'd0,   5'd31);
        send_event(KIND_READ,         10'd0,   5'd0);
        send_event(KIND_PROMOTE_DONE, 10'd0,   5'd1);
        send_event(KIND_READ,         10'd0,   5'd0);
        send_event(KIND_PROMOTE_DONE, 10'd0,   5'd0);
        send_event(KIND_READ,         10'd0,   5'd0);
        send_event(KIND_WRITE,        10'd0,   5'd0);
        send_event(KIND_OTHER,        10'd0,   5'd0);
        send_event(KIND_MARK,         10'd0,   5'd0);
        send_event(KIND_RECLAIM,      10'd0,   5'd0);
        send_event(KIND_RECLAIM,      10'd0,   5'd0);
        send_event(KIND_WRITE,        10'd0,   5'd0);
        send_event(KIND_PROMOTE_DONE, 10'd0,   5'd1);
        send_event(KIND_RESERVED_A,   10'd0,   5'd0);
        send_event(KIND_RESERVED_B,   10'd1023, 5'd31);
        send_event(KIND_MARK,         10'd1023, 5'd0);
        send_event(KIND_WRITE,        10'd1023, 5'd0);
        send_event(KIND_PROMOTE_DONE, 10'd1023, 5'd31);
        send_event(KIND_READ,         10'd1023, 5'd0);
        send_event(KIND_RECLAIM,      10'd1023, 5'd0);

        // Random traffic across page counts: single page, none, above table, full, small, mid-size, random
        run_phase(32'd1,    150, 1'b0);
        run_phase(32'd0,    20,  1'b0);
        run_phase(32'd2047, 300, 1'b0);
        run_phase(32'd1024, 300, 1'b1);
        run_phase(32'd5,    400, 1'b0);
        run_phase(32'd300,  250, 1'b0);
        run_phase(32'($urandom_range(PCST_PAGE_COUNT_MAX, 1)), 200, 1'b0);
        drain_results();

        $display("Sent %0d beats (%0d hitting live pages) over %0d page count settings;",
                 beats_sent, live_beats, settings_used + 1);
        $display("checked %0d results, %0d of them promotion copies.",
                 results_checked, promote_copies);
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #4_000_000;
        $display("Timeout with %0d results outstanding", results_owed);
        $display("== FAIL ==");
        $finish;
    end

endmodule

>>> files.f
+incdir+sv
sv/pcst_pkg.sv
sv/pcst_ram.sv
sv/pcst_update.sv
sv/page_cache_state_table_core.sv
tb/page_cache_state_table_checker.sv
tb/page_cache_state_table_core_tb.sv
